[sv/roizf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roizf_pkg
// Shared codes and types for the zone detection filter.
// ----------------------------------------------------------------------------
package roizf_pkg;

    typedef logic [1:0] role_t;
    typedef logic       kind_t;

    localparam kind_t KIND_WRITE = 1'b0;
    localparam kind_t KIND_TEST  = 1'b1;

    localparam role_t ROLE_DETECTION = 2'd0;
    localparam role_t ROLE_ALARM     = 2'd1;
    localparam role_t ROLE_EXCLUDE   = 2'd2;
    localparam role_t ROLE_IGNORED   = 2'd3;

    // smallest zone side that a write may store
    localparam int unsigned MIN_SIDE = 4;

    localparam int unsigned INDEX_BITS = 4;

endpackage

[sv/roizf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roizf_in_if / roizf_out_if
// Valid/ready channels for zone-filter requests and their results.
// ----------------------------------------------------------------------------
interface roizf_in_if #(
    parameter int COORD_BITS = 12
);
    import roizf_pkg::*;

    logic                            valid;
    logic                            ready;
    kind_t                           kind;
    logic [INDEX_BITS-1:0]           zone_index;
    logic [COORD_BITS-1:0]           rect_x;
    logic [COORD_BITS-1:0]           rect_y;
    logic [COORD_BITS-1:0]           rect_w;
    logic [COORD_BITS-1:0]           rect_h;
    logic                            zone_active;
    role_t                           zone_role;

    modport source (
        output valid, kind, zone_index, rect_x, rect_y, rect_w, rect_h,
               zone_active, zone_role,
        input  ready
    );

    modport sink (
        input  valid, kind, zone_index, rect_x, rect_y, rect_w, rect_h,
               zone_active, zone_role,
        output ready
    );
endinterface

interface roizf_out_if;
    logic valid;
    logic ready;
    logic keep;
    logic write_accepted;
    logic hit_exclude;
    logic hit_include;

    modport source (
        output valid, keep, write_accepted, hit_exclude, hit_include,
        input  ready
    );

    modport sink (
        input  valid, keep, write_accepted, hit_exclude, hit_include,
        output ready
    );
endinterface

[sv/roi_zone_detection_filter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roi_zone_detection_filter_top
// Include/exclude zone filter for detection boxes, one request per cycle unless stalled.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while results are taken, and
// returns one result per request. The request enters the input register at
// the edge that accepts it; the result register loads when it leaves that
// register, which holds it while an unread result stalls. A write request
// (kind 0) stores a zone at zone_index unless its width or height is below 4
// or the slot is past the table; write_accepted reports the outcome. A test
// request (kind 1) takes the box centroid (x + w/2, y + h/2, halves truncated)
// and compares it against every enabled zone at once, half-open on the far
// edges. keep is 0 for a write, when the centroid is in an exclude zone, or
// when include zones (detection or alarm role) are enabled and it is in none.
// The sustained rate of one request per cycle while results are taken is set
// by the parallel zone compare between the two registers; far zone edges are
// precomputed when a zone is written. A stalled result lets only an empty input
// register fill. Reset clears the zone enables; slots are 0 to SLOTS-1, at most 15.
// ----------------------------------------------------------------------------
module roi_zone_detection_filter_top #(
    parameter int ZONES      = 16,
    parameter int COORD_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    roizf_in_if.sink    item,
    roizf_out_if.source result
);
    import roizf_pkg::*;

    // only slots addressable by the index field can ever hold a zone
    localparam int SLOTS    = (ZONES < (1 << INDEX_BITS)) ? ZONES : (1 << INDEX_BITS);
    localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EDGE_BITS = COORD_BITS + 1;

    // ---------------- handshake control ----------------
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic advance;
    logic take;

    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;
    assign take       = item.valid && item.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- stage 1: input register ----------------
    // Centroid for tests, far edges and the size and slot check for writes.
    logic [EDGE_BITS-1:0] cx_next, cy_next, right_next, bottom_next;
    logic                 wr_ok_next;
    logic                 slot_ok;

    assign slot_ok = ({1'b0, item.zone_index} < (INDEX_BITS+1)'(SLOTS));

    always_comb
    begin
        cx_next     = {1'b0, item.rect_x} + {2'b00, item.rect_w[COORD_BITS-1:1]};
        cy_next     = {1'b0, item.rect_y} + {2'b00, item.rect_h[COORD_BITS-1:1]};
        right_next  = {1'b0, item.rect_x} + {1'b0, item.rect_w};
        bottom_next = {1'b0, item.rect_y} + {1'b0, item.rect_h};
        wr_ok_next  = (item.kind == KIND_WRITE) && slot_ok
                      && (item.rect_w >= COORD_BITS'(MIN_SIDE))
                      && (item.rect_h >= COORD_BITS'(MIN_SIDE));
    end

    kind_t                 kind_reg;
    logic [IDX_BITS-1:0]   idx_reg;
    logic [COORD_BITS-1:0] x_reg, y_reg;
    logic [EDGE_BITS-1:0]  cx_reg, cy_reg, right_reg, bottom_reg;
    logic                  active_reg;
    role_t                 role_reg;
    logic                  wr_ok_reg;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg   <= item.kind;
            idx_reg    <= item.zone_index[IDX_BITS-1:0];
            x_reg      <= item.rect_x;
            y_reg      <= item.rect_y;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
            active_reg <= item.zone_active;
            role_reg   <= item.zone_role;
            wr_ok_reg  <= wr_ok_next;
        end
    end

    // ---------------- zone table ----------------
    logic [COORD_BITS-1:0] left_reg  [SLOTS];
    logic [COORD_BITS-1:0] top_reg   [SLOTS];
    logic [EDGE_BITS-1:0]  rgt_reg   [SLOTS];
    logic [EDGE_BITS-1:0]  bot_reg   [SLOTS];
    role_t                 zrole_reg [SLOTS];
    logic [SLOTS-1:0]      enabled_reg;

    logic store;
    assign store = advance && wr_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= '0;
        end
        else if (store)
        begin
            enabled_reg[idx_reg] <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            left_reg[idx_reg]  <= x_reg;
            top_reg[idx_reg]   <= y_reg;
            rgt_reg[idx_reg]   <= right_reg;
            bot_reg[idx_reg]   <= bottom_reg;
            zrole_reg[idx_reg] <= role_reg;
        end
    end

    // ---------------- stage 2: parallel compare ----------------
    logic [SLOTS-1:0] in_zone, is_incl, is_excl;
    logic             any_incl, hit_in, hit_ex;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            in_zone[i] = (cx_reg >= {1'b0, left_reg[i]}) && (cx_reg < rgt_reg[i])
                         && (cy_reg >= {1'b0, top_reg[i]}) && (cy_reg < bot_reg[i]);
            is_incl[i] = enabled_reg[i]
                         && (zrole_reg[i] == ROLE_DETECTION || zrole_reg[i] == ROLE_ALARM);
            is_excl[i] = enabled_reg[i] && (zrole_reg[i] == ROLE_EXCLUDE);
        end
        any_incl = |is_incl;
        hit_in   = |(is_incl & in_zone);
        hit_ex   = |(is_excl & in_zone);
    end

    // ---------------- result register ----------------
    logic keep_reg, accepted_reg, hit_ex_reg, hit_in_reg;
    logic is_test;
    assign is_test = (kind_reg == KIND_TEST);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            accepted_reg <= wr_ok_reg;
            hit_ex_reg   <= is_test && hit_ex;
            hit_in_reg   <= is_test && hit_in;
            keep_reg     <= is_test && !hit_ex && (!any_incl || hit_in);
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.keep           = keep_reg;
    assign result.write_accepted = accepted_reg;
    assign result.hit_exclude    = hit_ex_reg;
    assign result.hit_include    = hit_in_reg;

endmodule
